### hdl/pd_position_hold_attitude_setpoint_unit_assert.svh
// Assertion macros shared by the position-hold setpoint unit.
`ifndef PD_POSITION_HOLD_ATTITUDE_SETPOINT_UNIT_ASSERT_SVH
`define PD_POSITION_HOLD_ATTITUDE_SETPOINT_UNIT_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define PDPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdph assertion failed");
// Next-cycle implication.
`define PDPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdph assertion failed");
`else
`define PDPH_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PDPH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hdl/pdph_pkg.sv
// Types, codes and table function for the position-hold setpoint unit.
`timescale 1ns / 1ps
package pdph_pkg;

    localparam logic [1:0] KIND_ESTIMATE = 2'd0;
    localparam logic [1:0] KIND_TARGET   = 2'd1;
    localparam logic [1:0] KIND_DEFAULT  = 2'd2;

    localparam logic [1:0] CFG_POSITION_GAIN = 2'd0;
    localparam logic [1:0] CFG_VELOCITY_GAIN = 2'd1;
    localparam logic [1:0] CFG_MAX_TILT      = 2'd2;

    localparam logic [3:0] MUL_PH_HI = 4'd0;
    localparam logic [3:0] MUL_PH_LO = 4'd1;
    localparam logic [3:0] MUL_KP_EX = 4'd2;
    localparam logic [3:0] MUL_KD_VX = 4'd3;
    localparam logic [3:0] MUL_KP_EY = 4'd4;
    localparam logic [3:0] MUL_KD_VY = 4'd5;
    localparam logic [3:0] MUL_AX_C  = 4'd6;
    localparam logic [3:0] MUL_AY_S  = 4'd7;
    localparam logic [3:0] MUL_AX_S  = 4'd8;
    localparam logic [3:0] MUL_AY_C  = 4'd9;

    localparam logic [2:0] ACC_HOLD     = 3'd0;
    localparam logic [2:0] ACC_LOAD     = 3'd1;
    localparam logic [2:0] ACC_LOAD_HI  = 3'd2;
    localparam logic [2:0] ACC_ADD      = 3'd3;
    localparam logic [2:0] ACC_ADD_RND  = 3'd4;
    localparam logic [2:0] ACC_SUB      = 3'd5;
    localparam logic [2:0] ACC_LOAD_NEG = 3'd6;

    localparam logic [63:0] PI_HALF_Q28 = 64'd421657428;
    localparam logic [63:0] INV_PI_Q32  = 64'd1367130551;

    typedef struct packed {
        logic       accept;
        logic [3:0] mul_sel;
        logic [2:0] acc_op;
        logic       ld_phase;
        logic       ph_step;
        logic       ld_ax;
        logic       ld_ay;
        logic       rom_sel_b;
        logic       ld_a;
        logic       ld_b;
        logic       ld_sc;
        logic       ld_pitch;
        logic       ld_out;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

    // Q14 sine of a Q28 angle by Taylor series; used at elaboration only.
    function automatic logic [14:0] sine_q14(input logic [63:0] x);
        logic [63:0] term;
        longint      sum;
        longint      r;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 10; k++) begin
            term = (((term * x) >> 28) * x) >> 28;
            // Divide by (2k)(2k+1) for this term.
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                default: term = term / 64'd420;
            endcase
            if (k[0] == 1'b1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 8192) >>> 14;
        if (r > 16384) begin
            r = 16384;
        end
        return 15'(r);
    endfunction

endpackage

### hdl/pdph_sine_rom.sv
// Quarter-wave sine table with a registered read port.
`timescale 1ns / 1ps
module pdph_sine_rom #(
    parameter int ENTRIES = 1024
) (
    input  logic                             i_clk,
    input  logic [$clog2(ENTRIES+1)-1:0]     i_addr,
    output logic [14:0]                      o_data
);
    logic [14:0] w_rom [0:ENTRIES];
    logic [14:0] r_data;

    for (genvar g = 0; g <= ENTRIES; g++) begin : g_entry
        localparam logic [63:0] ANGLE =
            (pdph_pkg::PI_HALF_Q28 * 64'(g) + 64'(ENTRIES / 2)) / 64'(ENTRIES);
        assign w_rom[g] = pdph_pkg::sine_q14(ANGLE);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;
endmodule

### hdl/pdph_ctrl.sv
// Sequencer for the estimate computation and the input handshake.
`timescale 1ns / 1ps
`include "pd_position_hold_attitude_setpoint_unit_assert.svh"
module pdph_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic [1:0]           i_kind,
    output logic                 o_in_ready,
    input  pdph_pkg::t_dp_status i_status,
    output pdph_pkg::t_dp_cmd    o_cmd
);
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_PH_HI = 5'd1;
    localparam logic [4:0] S_PH_LO = 5'd2;
    localparam logic [4:0] S_AX_P  = 5'd3;
    localparam logic [4:0] S_AX_V  = 5'd4;
    localparam logic [4:0] S_AY_P  = 5'd5;
    localparam logic [4:0] S_AY_V  = 5'd6;
    localparam logic [4:0] S_AY_F  = 5'd7;
    localparam logic [4:0] S_ROM_A = 5'd8;
    localparam logic [4:0] S_ROM_B = 5'd9;
    localparam logic [4:0] S_ROM_W = 5'd10;
    localparam logic [4:0] S_SC    = 5'd11;
    localparam logic [4:0] S_BX1   = 5'd12;
    localparam logic [4:0] S_BX2   = 5'd13;
    localparam logic [4:0] S_BY1   = 5'd14;
    localparam logic [4:0] S_BY2   = 5'd15;
    localparam logic [4:0] S_BYF   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_cmd.accept  = w_accept;
        o_cmd.mul_sel = pdph_pkg::MUL_PH_HI;
        o_cmd.acc_op  = pdph_pkg::ACC_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_kind == pdph_pkg::KIND_ESTIMATE) begin
                    n_state = S_PH_HI;
                end
            end
            S_PH_HI: begin
                o_cmd.mul_sel = pdph_pkg::MUL_PH_HI;
                n_state = S_PH_LO;
            end
            S_PH_LO: begin
                o_cmd.mul_sel = pdph_pkg::MUL_PH_LO;
                o_cmd.acc_op  = pdph_pkg::ACC_LOAD_HI;
                n_state = S_AX_P;
            end
            S_AX_P: begin
                o_cmd.mul_sel = pdph_pkg::MUL_KP_EX;
                o_cmd.acc_op  = pdph_pkg::ACC_ADD_RND;
                n_state = S_AX_V;
            end
            S_AX_V: begin
                o_cmd.mul_sel  = pdph_pkg::MUL_KD_VX;
                o_cmd.acc_op   = pdph_pkg::ACC_LOAD;
                o_cmd.ld_phase = 1'b1;
                n_state = S_AY_P;
            end
            S_AY_P: begin
                o_cmd.mul_sel = pdph_pkg::MUL_KP_EY;
                o_cmd.acc_op  = pdph_pkg::ACC_SUB;
                n_state = S_AY_V;
            end
            S_AY_V: begin
                o_cmd.mul_sel = pdph_pkg::MUL_KD_VY;
                o_cmd.acc_op  = pdph_pkg::ACC_LOAD;
                o_cmd.ld_ax   = 1'b1;
                o_cmd.ph_step = 1'b1;
                n_state = S_AY_F;
            end
            S_AY_F: begin
                o_cmd.acc_op  = pdph_pkg::ACC_SUB;
                o_cmd.ph_step = 1'b1;
                n_state = S_ROM_A;
            end
            S_ROM_A: begin
                o_cmd.ld_ay = 1'b1;
                n_state = S_ROM_B;
            end
            S_ROM_B: begin
                o_cmd.rom_sel_b = 1'b1;
                o_cmd.ld_a      = 1'b1;
                n_state = S_ROM_W;
            end
            S_ROM_W: begin
                o_cmd.ld_b = 1'b1;
                n_state = S_SC;
            end
            S_SC: begin
                o_cmd.ld_sc = 1'b1;
                n_state = S_BX1;
            end
            S_BX1: begin
                o_cmd.mul_sel = pdph_pkg::MUL_AX_C;
                n_state = S_BX2;
            end
            S_BX2: begin
                o_cmd.mul_sel = pdph_pkg::MUL_AY_S;
                o_cmd.acc_op  = pdph_pkg::ACC_LOAD;
                n_state = S_BY1;
            end
            S_BY1: begin
                o_cmd.mul_sel = pdph_pkg::MUL_AX_S;
                o_cmd.acc_op  = pdph_pkg::ACC_ADD;
                n_state = S_BY2;
            end
            S_BY2: begin
                o_cmd.mul_sel  = pdph_pkg::MUL_AY_C;
                o_cmd.acc_op   = pdph_pkg::ACC_LOAD_NEG;
                o_cmd.ld_pitch = 1'b1;
                n_state = S_BYF;
            end
            S_BYF: begin
                o_cmd.acc_op = pdph_pkg::ACC_ADD;
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold here until the output register is free.
                if (i_status.out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `PDPH_ASSERT_NEXT(a_est_busy, i_clk, i_rst_n, w_accept && i_kind == pdph_pkg::KIND_ESTIMATE, !o_in_ready)
    `PDPH_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, r_state == S_OUT && i_status.out_free, o_in_ready)
    `PDPH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_state == S_OUT && !i_status.out_free, r_state == S_OUT)
endmodule

### hdl/pdph_dp.sv
// Datapath: held target, registers, shared multiplier, phase and clamps.
`timescale 1ns / 1ps
module pdph_dp #(
    parameter int SINE_TABLE_ENTRIES     = 1024,
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pdph_pkg::t_dp_cmd    i_cmd,
    output pdph_pkg::t_dp_status o_status,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic [1:0]           i_kind,
    input  logic signed [31:0]   i_est_x,
    input  logic signed [31:0]   i_est_y,
    input  logic signed [31:0]   i_est_vel_x,
    input  logic signed [31:0]   i_est_vel_y,
    input  logic signed [15:0]   i_est_yaw,
    input  logic signed [31:0]   i_goal_x,
    input  logic signed [31:0]   i_goal_y,
    input  logic signed [15:0]   i_goal_yaw,
    input  logic                 i_goal_yaw_valid,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [15:0]   o_roll_setpoint,
    output logic signed [15:0]   o_pitch_setpoint,
    output logic signed [15:0]   o_yaw_setpoint
);
    localparam int N   = SINE_TABLE_ENTRIES;
    localparam int A_W = $clog2(N + 1);
    localparam int P_W = $clog2(4 * N);
    localparam int SH  = POSITION_FRACTION_BITS + 1;
    localparam logic [63:0] PHASE_K = 64'(2 * N) * pdph_pkg::INV_PI_Q32;
    localparam logic [P_W-1:0] N_P = P_W'(N);
    localparam logic [A_W-1:0] N_A = A_W'(N);

    logic [15:0] r_kp;
    logic [15:0] r_kd;
    logic [14:0] r_max;
    logic signed [31:0] r_tx;
    logic signed [31:0] r_ty;
    logic signed [15:0] r_tyaw;
    logic               r_tyaw_ok;

    logic signed [31:0] r_ex;
    logic signed [31:0] r_ey;
    logic signed [31:0] r_vx;
    logic signed [31:0] r_vy;
    logic [16:0]        r_mag;
    logic               r_neg;
    logic signed [15:0] r_yaw;

    logic signed [50:0] r_prod;
    logic signed [63:0] r_acc;
    logic [P_W-1:0]     r_p;
    logic [1:0]         r_q;
    logic signed [31:0] r_ax;
    logic signed [31:0] r_ay;
    logic [14:0]        r_a;
    logic [14:0]        r_b;
    logic signed [15:0] r_s;
    logic signed [15:0] r_c;
    logic signed [15:0] r_pitch;
    logic               r_out_valid;
    logic signed [15:0] r_roll_o;
    logic signed [15:0] r_pitch_o;
    logic signed [15:0] r_yaw_o;

    logic signed [32:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [63:0] w_prod64;
    logic [A_W-1:0]     w_addr;
    logic [14:0]        w_rom;
    logic signed [15:0] w_sa;
    logic signed [15:0] w_sb;
    logic signed [15:0] w_s;
    logic signed [15:0] w_c;

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -33'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_acc(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [15:0] clamp(input logic signed [63:0] v,
                                                 input logic [14:0] m);
        logic signed [63:0] mx;
        mx = $signed({49'd0, m});
        if (v > mx) begin
            return $signed({1'b0, m});
        end else if (v < -mx) begin
            return -$signed({1'b0, m});
        end
        return v[15:0];
    endfunction

    // Configuration writes; unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= '0;
            r_kd  <= '0;
            r_max <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdph_pkg::CFG_POSITION_GAIN: r_kp  <= i_cfg_data;
                pdph_pkg::CFG_VELOCITY_GAIN: r_kd  <= i_cfg_data;
                pdph_pkg::CFG_MAX_TILT:      r_max <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx      <= '0;
            r_ty      <= '0;
            r_tyaw    <= '0;
            r_tyaw_ok <= 1'b1;
        end else if (i_cmd.accept) begin
            case (i_kind)
                pdph_pkg::KIND_TARGET: begin
                    r_tx      <= i_goal_x;
                    r_ty      <= i_goal_y;
                    r_tyaw    <= i_goal_yaw;
                    r_tyaw_ok <= i_goal_yaw_valid;
                end
                pdph_pkg::KIND_DEFAULT: begin
                    r_tx      <= '0;
                    r_ty      <= '0;
                    r_tyaw    <= '0;
                    r_tyaw_ok <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Capture the estimate; form errors and yaw magnitude on the way in.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_kind == pdph_pkg::KIND_ESTIMATE) begin
            r_ex  <= sat32(33'(r_tx) - 33'(i_est_x));
            r_ey  <= sat32(33'(r_ty) - 33'(i_est_y));
            r_vx  <= i_est_vel_x;
            r_vy  <= i_est_vel_y;
            r_mag <= i_est_yaw[15] ? 17'(-33'(i_est_yaw)) : {1'b0, i_est_yaw};
            r_neg <= i_est_yaw[15];
            r_yaw <= r_tyaw_ok ? r_tyaw : i_est_yaw;
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            pdph_pkg::MUL_PH_HI: begin
                w_mul_a = $signed({1'b0, PHASE_K[63:32]});
                w_mul_b = $signed({1'b0, r_mag});
            end
            pdph_pkg::MUL_PH_LO: begin
                w_mul_a = $signed({1'b0, PHASE_K[31:0]});
                w_mul_b = $signed({1'b0, r_mag});
            end
            pdph_pkg::MUL_KP_EX: begin
                w_mul_a = 33'(r_ex);
                w_mul_b = $signed({2'b00, r_kp});
            end
            pdph_pkg::MUL_KD_VX: begin
                w_mul_a = 33'(r_vx);
                w_mul_b = $signed({2'b00, r_kd});
            end
            pdph_pkg::MUL_KP_EY: begin
                w_mul_a = 33'(r_ey);
                w_mul_b = $signed({2'b00, r_kp});
            end
            pdph_pkg::MUL_KD_VY: begin
                w_mul_a = 33'(r_vy);
                w_mul_b = $signed({2'b00, r_kd});
            end
            pdph_pkg::MUL_AX_C: begin
                w_mul_a = 33'(r_ax);
                w_mul_b = 18'(r_c);
            end
            pdph_pkg::MUL_AY_S: begin
                w_mul_a = 33'(r_ay);
                w_mul_b = 18'(r_s);
            end
            pdph_pkg::MUL_AX_S: begin
                w_mul_a = 33'(r_ax);
                w_mul_b = 18'(r_s);
            end
            pdph_pkg::MUL_AY_C: begin
                w_mul_a = 33'(r_ay);
                w_mul_b = 18'(r_c);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod64 = 64'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= 51'(w_mul_a * w_mul_b);
        case (i_cmd.acc_op)
            pdph_pkg::ACC_LOAD:     r_acc <= w_prod64;
            pdph_pkg::ACC_LOAD_HI:  r_acc <= w_prod64 <<< 32;
            pdph_pkg::ACC_ADD:      r_acc <= r_acc + w_prod64;
            pdph_pkg::ACC_ADD_RND:  r_acc <= r_acc + w_prod64 + (64'sd1 <<< 44);
            pdph_pkg::ACC_SUB:      r_acc <= r_acc - w_prod64;
            pdph_pkg::ACC_LOAD_NEG: r_acc <= -w_prod64;
            default: ;
        endcase
    end

    // Phase: take p from the product sum, then two compare-subtract steps.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_phase) begin
            r_p <= r_acc[45 +: P_W];
            r_q <= 2'd0;
        end else if (i_cmd.ph_step && r_p >= N_P) begin
            r_p <= r_p - N_P;
            r_q <= r_q + 2'd1;
        end
    end

    assign w_addr = i_cmd.rom_sel_b ? (N_A - r_p[A_W-1:0]) : r_p[A_W-1:0];

    pdph_sine_rom #(
        .ENTRIES (N)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_addr),
        .o_data (w_rom)
    );

    assign w_sa = $signed({1'b0, r_a});
    assign w_sb = $signed({1'b0, r_b});

    always_comb begin
        case (r_q)
            2'd0: begin
                w_s = w_sa;
                w_c = w_sb;
            end
            2'd1: begin
                w_s = w_sb;
                w_c = -w_sa;
            end
            2'd2: begin
                w_s = -w_sa;
                w_c = -w_sb;
            end
            default: begin
                w_s = -w_sb;
                w_c = w_sa;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_ax) begin
            r_ax <= sat_acc(r_acc >>> 8);
        end
        if (i_cmd.ld_ay) begin
            r_ay <= sat_acc(r_acc >>> 8);
        end
        if (i_cmd.ld_a) begin
            r_a <= w_rom;
        end
        if (i_cmd.ld_b) begin
            r_b <= w_rom;
        end
        if (i_cmd.ld_sc) begin
            r_s <= r_neg ? -w_s : w_s;
            r_c <= w_c;
        end
        if (i_cmd.ld_pitch) begin
            r_pitch <= clamp(r_acc >>> SH, r_max);
        end
        if (i_cmd.ld_out) begin
            r_roll_o  <= -clamp(r_acc >>> SH, r_max);
            r_pitch_o <= r_pitch;
            r_yaw_o   <= r_yaw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.ld_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_roll_setpoint   = r_roll_o;
    assign o_pitch_setpoint  = r_pitch_o;
    assign o_yaw_setpoint    = r_yaw_o;
endmodule

### hdl/pd_position_hold_attitude_setpoint_unit.sv
// Top level of the position-hold PD attitude setpoint unit.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_ready   i_kind, i_est_*, i_goal_*
//  output   out        o_out_valid / i_out_ready o_roll/pitch/yaw_setpoint
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A target or default-target transaction yields no result.
// An estimate transaction blocks the next accept while it is computed:
// one shared 33x18 multiplier steps through ten products (phase, gains, and
// rotation) and the sine table is read twice through its single port.
// The result sits in an output register; a new transaction is accepted while it
// waits, and the sequencer holds in its last step only if the register is full.
// Reset (synchronous, active low) clears gains, tilt limit and restores the
// default target: zero position, zero yaw, yaw marked valid.
`timescale 1ns / 1ps
module pd_position_hold_attitude_setpoint_unit #(
    parameter int SINE_TABLE_ENTRIES     = 1024,
    parameter int POSITION_FRACTION_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic signed [31:0] i_est_x,
    input  logic signed [31:0] i_est_y,
    input  logic signed [31:0] i_est_vel_x,
    input  logic signed [31:0] i_est_vel_y,
    input  logic signed [15:0] i_est_yaw,
    input  logic signed [31:0] i_goal_x,
    input  logic signed [31:0] i_goal_y,
    input  logic signed [15:0] i_goal_yaw,
    input  logic               i_goal_yaw_valid,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_roll_setpoint,
    output logic signed [15:0] o_pitch_setpoint,
    output logic signed [15:0] o_yaw_setpoint,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    pdph_pkg::t_dp_cmd    w_cmd;
    pdph_pkg::t_dp_status w_status;

    // Configuration is always ready and lands at once; write it only while no
    // estimate is in flight.
    assign o_cfg_ready = 1'b1;

    pdph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pdph_dp #(
        .SINE_TABLE_ENTRIES     (SINE_TABLE_ENTRIES),
        .POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_cfg_we         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_kind           (i_kind),
        .i_est_x          (i_est_x),
        .i_est_y          (i_est_y),
        .i_est_vel_x      (i_est_vel_x),
        .i_est_vel_y      (i_est_vel_y),
        .i_est_yaw        (i_est_yaw),
        .i_goal_x         (i_goal_x),
        .i_goal_y         (i_goal_y),
        .i_goal_yaw       (i_goal_yaw),
        .i_goal_yaw_valid (i_goal_yaw_valid),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_roll_setpoint  (o_roll_setpoint),
        .o_pitch_setpoint (o_pitch_setpoint),
        .o_yaw_setpoint   (o_yaw_setpoint)
    );
endmodule

### test/testbench.sv
// Self-checking testbench for the position-hold PD attitude setpoint unit.
`timescale 1ns / 1ps
module testbench;

    // Kind 3 is not defined; the unit must drop it.
    localparam logic [1:0] KIND_UNDEFINED = 2'd3;
    // Index 3 maps to no register; the write must be dropped.
    localparam logic [1:0] CFG_UNUSED     = 2'd3;
    localparam int TABLE_N     = 1024;
    localparam int FRAC_BITS   = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN       = 24;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] est_x;
        logic signed [31:0] est_y;
        logic signed [31:0] est_vel_x;
        logic signed [31:0] est_vel_y;
        logic signed [15:0] est_yaw;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [15:0] goal_yaw;
        logic               goal_yaw_valid;
    } t_item;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
    } t_setpoint;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic signed [31:0] i_est_x;
    logic signed [31:0] i_est_y;
    logic signed [31:0] i_est_vel_x;
    logic signed [31:0] i_est_vel_y;
    logic signed [15:0] i_est_yaw;
    logic signed [31:0] i_goal_x;
    logic signed [31:0] i_goal_y;
    logic signed [15:0] i_goal_yaw;
    logic               i_goal_yaw_valid;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_roll_setpoint;
    logic signed [15:0] o_pitch_setpoint;
    logic signed [15:0] o_yaw_setpoint;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    pd_position_hold_attitude_setpoint_unit uut (.*);

    // Predictor state: registers, held target and the quarter-wave table.
    longint    kp_gain;
    longint    kd_gain;
    longint    tilt_limit;
    longint    tgt_x;
    longint    tgt_y;
    longint    tgt_yaw;
    bit        tgt_yaw_ok;
    longint    quarter_sine [0:TABLE_N];
    t_setpoint setpoint_queue [$];

    int send_idle_pct;
    int recv_stall_pct;
    int mismatches;
    int setpoints_seen;
    int items_sent;
    int stall_cycles;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Fill the table with a Q28 Taylor series rounded to Q14.
    task automatic fill_quarter_sine();
        longint unsigned ang;
        longint unsigned term;
        longint          acc;
        longint          val;
        for (int i = 0; i <= TABLE_N; i++) begin
            ang  = (64'd421657428 * i + TABLE_N / 2) / TABLE_N;
            term = ang;
            acc  = ang;
            for (int k = 1; k <= 10; k++) begin
                term = (((term * ang) >> 28) * ang) >> 28;
                term = term / ((2 * k) * (2 * k + 1));
                if (k % 2 == 1) begin
                    acc = acc - longint'(term);
                end else begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0) begin
                acc = 0;
            end
            val = (acc + 8192) >>> 14;
            quarter_sine[i] = (val > 16384) ? 16384 : val;
        end
    endtask

    function automatic longint sat_word(longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint limit_tilt(longint v);
        if (v > tilt_limit) begin
            return tilt_limit;
        end
        if (v < -tilt_limit) begin
            return -tilt_limit;
        end
        return v;
    endfunction

    // Advance the held target or compute the setpoint for one transaction.
    task automatic predict_setpoint(input t_item it);
        longint          err_x;
        longint          err_y;
        longint          acc_x;
        longint          acc_y;
        longint          yaw;
        longint unsigned mag;
        longint unsigned phase;
        longint unsigned quad;
        longint unsigned ofs;
        longint          sa;
        longint          sb;
        longint          sn;
        longint          cs;
        longint          body_x;
        longint          body_y;
        t_setpoint       sp;
        case (it.kind)
            pdph_pkg::KIND_TARGET: begin
                tgt_x      = it.goal_x;
                tgt_y      = it.goal_y;
                tgt_yaw    = it.goal_yaw;
                tgt_yaw_ok = it.goal_yaw_valid;
            end
            pdph_pkg::KIND_DEFAULT: begin
                tgt_x      = 0;
                tgt_y      = 0;
                tgt_yaw    = 0;
                tgt_yaw_ok = 1'b1;
            end
            pdph_pkg::KIND_ESTIMATE: begin
                err_x = sat_word(tgt_x - longint'(it.est_x));
                err_y = sat_word(tgt_y - longint'(it.est_y));
                acc_x = sat_word((kp_gain * err_x - kd_gain * longint'(it.est_vel_x)) >>> 8);
                acc_y = sat_word((kp_gain * err_y - kd_gain * longint'(it.est_vel_y)) >>> 8);
                yaw   = it.est_yaw;
                mag   = (yaw < 0) ? -yaw : yaw;
                phase = (mag * 2 * TABLE_N * 64'd1367130551 + (64'd1 << 44)) >> 45;
                quad  = (phase / TABLE_N) % 4;
                ofs   = phase % TABLE_N;
                sa    = quarter_sine[ofs];
                sb    = quarter_sine[TABLE_N - ofs];
                case (quad)
                    0: begin sn = sa;  cs = sb;  end
                    1: begin sn = sb;  cs = -sa; end
                    2: begin sn = -sa; cs = -sb; end
                    default: begin sn = -sb; cs = sa; end
                endcase
                if (yaw < 0) begin
                    sn = -sn;
                end
                body_x   = acc_x * cs + acc_y * sn;
                body_y   = -acc_x * sn + acc_y * cs;
                sp.pitch = 16'(limit_tilt(body_x >>> (FRAC_BITS + 1)));
                sp.roll  = 16'(-limit_tilt(body_y >>> (FRAC_BITS + 1)));
                sp.yaw   = tgt_yaw_ok ? 16'(tgt_yaw) : it.est_yaw;
                setpoint_queue.push_back(sp);
            end
            default: begin
                // drop: undefined kind leaves everything as it was
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Drive the output stall pattern and check every accepted setpoint.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_out_valid && i_out_ready) begin
                setpoints_seen++;
                if (setpoint_queue.size() == 0) begin
                    report_mismatch("unexpected setpoint", 1, 0);
                end else begin
                    if (o_roll_setpoint !== setpoint_queue[0].roll) begin
                        report_mismatch("roll", o_roll_setpoint, setpoint_queue[0].roll);
                    end
                    if (o_pitch_setpoint !== setpoint_queue[0].pitch) begin
                        report_mismatch("pitch", o_pitch_setpoint, setpoint_queue[0].pitch);
                    end
                    if (o_yaw_setpoint !== setpoint_queue[0].yaw) begin
                        report_mismatch("yaw", o_yaw_setpoint, setpoint_queue[0].yaw);
                    end
                    void'(setpoint_queue.pop_front());
                end
            end
        end
    end

    // Watchdog: count cycles with no transaction on any channel.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout with %0d setpoints pending", setpoint_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Send one item; valid stays high into the next item unless an idle gap follows.
    task automatic send_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_kind           <= it.kind;
        i_est_x          <= it.est_x;
        i_est_y          <= it.est_y;
        i_est_vel_x      <= it.est_vel_x;
        i_est_vel_y      <= it.est_vel_y;
        i_est_yaw        <= it.est_yaw;
        i_goal_x         <= it.goal_x;
        i_goal_y         <= it.goal_y;
        i_goal_yaw       <= it.goal_yaw;
        i_goal_yaw_valid <= it.goal_yaw_valid;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        items_sent++;
        predict_setpoint(it);
    endtask

    // Drain the setpoints, then let the sequencer settle before a register write.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (setpoint_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            pdph_pkg::CFG_POSITION_GAIN: kp_gain    = data;
            pdph_pkg::CFG_VELOCITY_GAIN: kd_gain    = data;
            pdph_pkg::CFG_MAX_TILT:      tilt_limit = data[14:0];
            default: begin
            end
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_gains(input logic [15:0] kp, input logic [15:0] kd, input logic [15:0] tilt);
        wait_idle();
        write_reg(pdph_pkg::CFG_POSITION_GAIN, kp);
        write_reg(pdph_pkg::CFG_VELOCITY_GAIN, kd);
        write_reg(pdph_pkg::CFG_MAX_TILT, tilt);
    endtask

    function automatic t_item estimate(input longint x, input longint y, input longint vx,
                                       input longint vy, input longint yaw);
        t_item it;
        it           = '0;
        it.kind      = pdph_pkg::KIND_ESTIMATE;
        it.est_x     = 32'(x);
        it.est_y     = 32'(y);
        it.est_vel_x = 32'(vx);
        it.est_vel_y = 32'(vy);
        it.est_yaw   = 16'(yaw);
        return it;
    endfunction

    function automatic t_item target(input longint x, input longint y, input longint yaw,
                                     input bit ok);
        t_item it;
        it                = '0;
        it.kind           = pdph_pkg::KIND_TARGET;
        it.goal_x         = 32'(x);
        it.goal_y         = 32'(y);
        it.goal_yaw       = 16'(yaw);
        it.goal_yaw_valid = ok;
        return it;
    endfunction

    // Random field value: mostly near the operating range, sometimes full width.
    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($signed($urandom_range(65535)) - 32768) <<< 8;
            default: return 32'(int'($urandom_range(1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic t_item random_item();
        t_item it;
        int    pick;
        it                = '0;
        pick              = $urandom_range(99);
        it.est_x          = rand_word();
        it.est_y          = rand_word();
        it.est_vel_x      = rand_word();
        it.est_vel_y      = rand_word();
        it.est_yaw        = 16'($urandom);
        it.goal_x         = rand_word();
        it.goal_y         = rand_word();
        it.goal_yaw       = 16'($urandom);
        it.goal_yaw_valid = 1'($urandom);
        if (pick < 75) begin
            it.kind = pdph_pkg::KIND_ESTIMATE;
        end else if (pick < 90) begin
            it.kind = pdph_pkg::KIND_TARGET;
        end else if (pick < 96) begin
            it.kind = pdph_pkg::KIND_DEFAULT;
        end else begin
            it.kind = KIND_UNDEFINED;
        end
        return it;
    endfunction

    // Extremes of every field, each kind, invalid goal yaw and zero tilt limit.
    task automatic test_directed();
        t_item it;
        set_gains(16'h0100, 16'h0080, 16'h0000);
        send_item(estimate(32'sd65536, -32'sd65536, 32'sd1000, -32'sd1000, 16'sd6000));
        wait_idle();
        write_reg(CFG_UNUSED, 16'hFFFF);
        set_gains(16'hFFFF, 16'hFFFF, 16'h7FFF);
        send_item(estimate(0, 0, 0, 0, 0));
        send_item(estimate(-32'sd2147483648, 32'sd2147483647, 0, 0, -16'sd32768));
        send_item(target(32'sd2147483647, -32'sd2147483648, 16'sd32767, 1'b1));
        send_item(estimate(-32'sd2147483648, 32'sd2147483647, 32'sd2147483647,
                           -32'sd2147483648, 16'sd32767));
        send_item(target(32'sd200000, -32'sd300000, -16'sd32768, 1'b0));
        send_item(estimate(32'sd100, 32'sd100, 0, 0, 16'sd12868));
        send_item(estimate(0, 0, -32'sd70000, 32'sd70000, -16'sd12868));
        it      = estimate(5, 5, 5, 5, 5);
        it.kind = KIND_UNDEFINED;
        send_item(it);
        send_item(estimate(32'sd1, -32'sd1, 0, 0, 16'sd25736));
        it      = target(0, 0, 0, 1'b0);
        it.kind = pdph_pkg::KIND_DEFAULT;
        send_item(it);
        send_item(estimate(32'sd50000, 32'sd50000, 0, 0, -16'sd1));
        set_gains(16'h0200, 16'h0100, 16'h0333);
        send_item(estimate(32'sd500000, -32'sd700000, 32'sd20000, 32'sd1, 16'sd3217));
        send_item(estimate(-32'sd65536, 32'sd65536, 0, 0, -16'sd19302));
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++) begin
            send_item(random_item());
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_kind           = pdph_pkg::KIND_ESTIMATE;
        i_est_x          = '0;
        i_est_y          = '0;
        i_est_vel_x      = '0;
        i_est_vel_y      = '0;
        i_est_yaw        = '0;
        i_goal_x         = '0;
        i_goal_y         = '0;
        i_goal_yaw       = '0;
        i_goal_yaw_valid = 1'b0;
        i_out_ready      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = pdph_pkg::CFG_POSITION_GAIN;
        i_cfg_data       = '0;
        kp_gain          = 0;
        kd_gain          = 0;
        tilt_limit       = 0;
        tgt_x            = 0;
        tgt_y            = 0;
        tgt_yaw          = 0;
        tgt_yaw_ok       = 1'b1;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        mismatches       = 0;
        setpoints_seen   = 0;
        items_sent       = 0;
        stall_cycles     = 0;
        fill_quarter_sine();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        // Each phase runs under its own register setting, extremes included.
        set_gains(16'h0100, 16'h0100, 16'h7FFF);
        test_random(500, 0, 0);
        set_gains(16'($urandom), 16'($urandom), 16'h0000);
        test_random(300, 88, 0);
        set_gains(16'hFFFF, 16'h0000, 16'h1000);
        test_random(300, 0, 88);
        set_gains(16'h0000, 16'hFFFF, 16'h7FFF);
        test_random(250, 17, 17);
        set_gains(16'($urandom_range(1024)), 16'($urandom_range(1024)),
                  16'($urandom_range(32767)));
        test_random(480, 0, 0);

        wait_idle();
        $display("Sent %0d items and checked %0d setpoints under several register settings",
                 items_sent, setpoints_seen);
        $display("and four idle/stall mixes, with %0d mismatches.", mismatches);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
